@@ design/soa_pkg.sv @@
// Shared constants for the slab object allocator: defaults, codes and field widths.
package soa_pkg;

    localparam int NUM_SLABS_DEF   = 16;
    localparam int MAX_OBJECTS_DEF = 64;

    // configuration register indexes
    localparam logic [1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_SLAB_SHIFT   = 2'd1;
    localparam logic [1:0] CFG_OBJECT_SIZE  = 2'd2;
    localparam logic [1:0] CFG_OBJECTS      = 2'd3;

    // result status codes
    localparam logic [2:0] ST_ALLOCATED = 3'd0;
    localparam logic [2:0] ST_OUT_OF_SLABS = 3'd1;
    localparam logic [2:0] ST_FREED = 3'd2;
    localparam logic [2:0] ST_RELEASED = 3'd3;
    localparam logic [2:0] ST_BAD_FREE = 3'd4;

    // request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam int DIV_BITS = 20;   // offset inside a slab is below 2^20

endpackage

@@ design/slab_object_allocator_top.sv @@
// Slab object allocator: slot table, chain memories and request sequencer.
// Alloc: a partial slab is read, addressed and updated; else slots are scanned lowest first
//   and a new slab's chain is built (one chain link per cycle), or out of slabs after the last.
// Free: address split, 20-step divider, check and update, plus a push when a full slab rejoins.
// Throughput: one request at a time; the next beat is taken once the result is registered.
// Reset (aresetn, synchronous): control, in-use bits and list head cleared; memories are not.
module slab_object_allocator_top #(
    parameter int NUM_SLABS   = soa_pkg::NUM_SLABS_DEF,
    parameter int MAX_OBJECTS = soa_pkg::MAX_OBJECTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] address
    input  logic        s_tuser,   // [0] req_type
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] object_address, [35:32] slab_index,
                                   // [42:36] free_left, [47:43] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import soa_pkg::*;

    localparam int SW = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
    localparam int OW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CW = $clog2(MAX_OBJECTS + 1);
    localparam int AW = $clog2(NUM_SLABS * MAX_OBJECTS);
    localparam int NF_DEPTH = NUM_SLABS * MAX_OBJECTS;
    localparam logic [SW:0] NULL_S = (SW+1)'(NUM_SLABS);
    localparam logic [SW-1:0] LAST_S = SW'(NUM_SLABS - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_A_RD  = 4'd1;
    localparam logic [3:0] S_A_OBJ = 4'd2;
    localparam logic [3:0] S_A_UPD = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_CHAIN = 4'd5;
    localparam logic [3:0] S_SETUP = 4'd6;
    localparam logic [3:0] S_F_OFF = 4'd7;
    localparam logic [3:0] S_F_DIV = 4'd8;
    localparam logic [3:0] S_F_EVAL = 4'd9;
    localparam logic [3:0] S_F_PUSH = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    typedef struct packed {
        logic [CW-1:0] cnt;    // available objects
        logic [OW-1:0] head;   // top of free chain
    } slot_ent_t;

    // slot table and list memories, one entry per slab
    slot_ent_t   slot_mem [NUM_SLABS];
    logic [SW:0] pn_mem   [NUM_SLABS];
    logic [SW:0] pp_mem   [NUM_SLABS];
    // free chain links, one per object of every slab
    logic [OW-1:0] nf_mem [NF_DEPTH];

    slot_ent_t     slot_rd_reg;
    logic [SW:0]   pn_rd_reg;
    logic [SW:0]   pp_rd_reg;
    logic [OW-1:0] nf_rd_reg;

    logic          slot_we;
    slot_ent_t     slot_wdata;
    logic          pn_we, pp_we, nf_we;
    logic [SW-1:0] pn_waddr, pp_waddr;
    logic [SW:0]   pn_wdata, pp_wdata;
    logic [AW-1:0] nf_waddr, nf_raddr;
    logic [OW-1:0] nf_wdata;

    // configuration
    logic [31:0] base_reg;
    logic [4:0]  shift_cfg_reg;
    logic [16:0] size_cfg_reg;
    logic [6:0]  objs_cfg_reg;

    // control and datapath registers
    logic [3:0]         state_reg, state_next;
    logic [SW-1:0]      idx_reg, idx_next;
    logic [OW-1:0]      k_reg, k_next;
    logic [4:0]         step_reg, step_next;
    logic [31:0]        addr_reg, addr_next;
    logic               bad_reg, bad_next;
    logic [16:0]        rem_reg, rem_next;
    logic [DIV_BITS-1:0] q_reg, q_next;
    logic [31:0]        slot_base_reg, slot_base_next;
    logic [31:0]        prod_reg, prod_next;
    logic [SW:0]        ph_reg, ph_next;
    logic [NUM_SLABS-1:0] in_use_reg, in_use_next;
    logic [2:0]         res_st_reg, res_st_next;
    logic [31:0]        res_addr_reg, res_addr_next;
    logic [3:0]         res_slot_reg, res_slot_next;
    logic [6:0]         res_left_reg, res_left_next;
    logic               m_valid_reg, m_valid_next;
    logic [47:0]        m_data_reg, m_data_next;
    logic [2:0]         m_user_reg, m_user_next;

    // clamped configuration
    logic [4:0]    shift_eff;
    logic [16:0]   size_eff;
    logic [CW-1:0] objs_eff;

    always_comb begin
        if (shift_cfg_reg < 5'd12) begin
            shift_eff = 5'd12;
        end else if (shift_cfg_reg > 5'd20) begin
            shift_eff = 5'd20;
        end else begin
            shift_eff = shift_cfg_reg;
        end
        if (size_cfg_reg < 17'd4) begin
            size_eff = 17'd4;
        end else begin
            size_eff = size_cfg_reg;   // values above 65536 are clamped below
        end
        if (size_cfg_reg > 17'd65536) begin
            size_eff = 17'd65536;
        end
        if (objs_cfg_reg == 7'd0) begin
            objs_eff = CW'(1);
        end else if (32'(objs_cfg_reg) > MAX_OBJECTS) begin
            objs_eff = CW'(MAX_OBJECTS);
        end else begin
            objs_eff = CW'(objs_cfg_reg);
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    // free-path address split
    logic [31:0]          off;
    logic [31:0]          slot_full;
    logic [DIV_BITS-1:0]  slab_off;
    logic [17:0]          trial;
    logic [CW-1:0]        cnt_dec, cnt_inc;
    logic [OW-1:0]        obj_q;

    assign off       = addr_reg - base_reg;
    assign slot_full = off >> shift_eff;
    assign slab_off  = off[DIV_BITS-1:0] & ((DIV_BITS'(1) << shift_eff) - DIV_BITS'(1));
    assign trial     = {rem_reg, q_reg[DIV_BITS-1]};
    assign cnt_dec   = (slot_rd_reg.cnt != '0) ? slot_rd_reg.cnt - CW'(1) : '0;
    assign cnt_inc   = slot_rd_reg.cnt + CW'(1);
    assign obj_q     = q_reg[OW-1:0];

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        step_next      = step_reg;
        addr_next      = addr_reg;
        bad_next       = bad_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        slot_base_next = slot_base_reg;
        prod_next      = prod_reg;
        ph_next        = ph_reg;
        in_use_next    = in_use_reg;
        res_st_next    = res_st_reg;
        res_addr_next  = res_addr_reg;
        res_slot_next  = res_slot_reg;
        res_left_next  = res_left_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;

        slot_we    = 1'b0;
        slot_wdata = slot_rd_reg;
        pn_we      = 1'b0;
        pn_waddr   = idx_reg;
        pn_wdata   = NULL_S;
        pp_we      = 1'b0;
        pp_waddr   = idx_reg;
        pp_wdata   = NULL_S;
        nf_we      = 1'b0;
        nf_waddr   = AW'(idx_reg) * AW'(MAX_OBJECTS) + AW'(k_reg);
        nf_wdata   = '0;
        nf_raddr   = AW'(idx_reg) * AW'(MAX_OBJECTS) + AW'(slot_rd_reg.head);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    addr_next = s_tdata;
                    if (s_tuser == REQ_ALLOC) begin
                        if (ph_reg < NULL_S) begin
                            idx_next   = ph_reg[SW-1:0];
                            state_next = S_A_RD;
                        end else begin
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                    end else begin
                        state_next = S_F_OFF;
                    end
                end
            end

            // partial slab at list head
            S_A_RD: begin
                state_next = S_A_OBJ;
            end
            S_A_OBJ: begin
                prod_next      = 32'(slot_rd_reg.head) * 32'(size_eff);
                slot_base_next = base_reg + (32'(idx_reg) << shift_eff);
                state_next     = S_A_UPD;
            end
            S_A_UPD: begin
                slot_we         = 1'b1;
                slot_wdata.cnt  = cnt_dec;
                slot_wdata.head = nf_rd_reg;
                if (cnt_dec == '0) begin
                    if (pp_rd_reg < NULL_S) begin
                        pn_we    = 1'b1;
                        pn_waddr = pp_rd_reg[SW-1:0];
                        pn_wdata = pn_rd_reg;
                    end else begin
                        ph_next = pn_rd_reg;
                    end
                    if (pn_rd_reg < NULL_S) begin
                        pp_we    = 1'b1;
                        pp_waddr = pn_rd_reg[SW-1:0];
                        pp_wdata = pp_rd_reg;
                    end
                end
                res_st_next   = ST_ALLOCATED;
                res_addr_next = slot_base_reg + prod_reg;
                res_slot_next = 4'(idx_reg);
                res_left_next = 7'(cnt_dec);
                state_next    = S_FIN;
            end

            // lowest free slot, one per cycle
            S_SCAN: begin
                if (!in_use_reg[idx_reg]) begin
                    in_use_next[idx_reg] = 1'b1;
                    k_next         = '0;
                    slot_base_next = base_reg + (32'(idx_reg) << shift_eff);
                    state_next     = S_CHAIN;
                end else if (idx_reg == LAST_S) begin
                    res_st_next   = ST_OUT_OF_SLABS;
                    res_addr_next = '0;
                    res_slot_next = '0;
                    res_left_next = '0;
                    state_next    = S_FIN;
                end else begin
                    idx_next = idx_reg + SW'(1);
                end
            end
            // address-order chain, one link per cycle
            S_CHAIN: begin
                nf_we = 1'b1;
                if (32'(k_reg) + 32'd1 < 32'(objs_eff)) begin
                    nf_wdata = k_reg + OW'(1);
                    k_next   = k_reg + OW'(1);
                end else begin
                    nf_wdata   = '0;
                    state_next = S_SETUP;
                end
            end
            // object 0 handed out at once; list was empty here
            S_SETUP: begin
                slot_we         = 1'b1;
                slot_wdata.cnt  = objs_eff - CW'(1);
                slot_wdata.head = (objs_eff > CW'(1)) ? OW'(1) : '0;
                pn_we   = 1'b1;
                pp_we   = 1'b1;
                ph_next = (objs_eff > CW'(1)) ? {1'b0, idx_reg} : NULL_S;
                res_st_next   = ST_ALLOCATED;
                res_addr_next = slot_base_reg;
                res_slot_next = 4'(idx_reg);
                res_left_next = 7'(objs_eff - CW'(1));
                state_next    = S_FIN;
            end

            // free: split address, then divide offset by object size
            S_F_OFF: begin
                bad_next   = (slot_full >= 32'(NUM_SLABS));
                idx_next   = slot_full[SW-1:0];
                rem_next   = '0;
                q_next     = slab_off;
                step_next  = '0;
                state_next = S_F_DIV;
            end
            S_F_DIV: begin
                if (trial >= {1'b0, size_eff}) begin
                    rem_next = 17'(trial - {1'b0, size_eff});
                    q_next   = {q_reg[DIV_BITS-2:0], 1'b1};
                end else begin
                    rem_next = trial[16:0];
                    q_next   = {q_reg[DIV_BITS-2:0], 1'b0};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(DIV_BITS - 1)) begin
                    state_next = S_F_EVAL;
                end
            end
            S_F_EVAL: begin
                nf_waddr = AW'(idx_reg) * AW'(MAX_OBJECTS) + AW'(obj_q);
                if (bad_reg || !in_use_reg[idx_reg] || rem_reg != '0 ||
                        q_reg >= DIV_BITS'(objs_eff) || slot_rd_reg.cnt >= objs_eff) begin
                    res_st_next   = ST_BAD_FREE;
                    res_addr_next = '0;
                    res_slot_next = '0;
                    res_left_next = '0;
                    state_next    = S_FIN;
                end else begin
                    nf_we           = 1'b1;
                    nf_wdata        = slot_rd_reg.head;
                    slot_we         = 1'b1;
                    slot_wdata.head = obj_q;
                    res_addr_next   = '0;
                    res_slot_next   = 4'(idx_reg);
                    if (cnt_inc == objs_eff) begin
                        // all objects back: release slot
                        slot_wdata.cnt       = '0;
                        in_use_next[idx_reg] = 1'b0;
                        if (cnt_inc != CW'(1)) begin
                            if (pp_rd_reg < NULL_S) begin
                                pn_we    = 1'b1;
                                pn_waddr = pp_rd_reg[SW-1:0];
                                pn_wdata = pn_rd_reg;
                            end else begin
                                ph_next = pn_rd_reg;
                            end
                            if (pn_rd_reg < NULL_S) begin
                                pp_we    = 1'b1;
                                pp_waddr = pn_rd_reg[SW-1:0];
                                pp_wdata = pp_rd_reg;
                            end
                        end
                        res_st_next   = ST_RELEASED;
                        res_left_next = 7'(objs_eff);
                        state_next    = S_FIN;
                    end else begin
                        slot_wdata.cnt = cnt_inc;
                        res_st_next    = ST_FREED;
                        res_left_next  = 7'(cnt_inc);
                        if (cnt_inc == CW'(1)) begin
                            // was full: push to list head
                            pp_we      = 1'b1;
                            pn_we      = 1'b1;
                            pn_wdata   = ph_reg;
                            state_next = S_F_PUSH;
                        end else begin
                            state_next = S_FIN;
                        end
                    end
                end
            end
            S_F_PUSH: begin
                if (ph_reg < NULL_S) begin
                    pp_we    = 1'b1;
                    pp_waddr = ph_reg[SW-1:0];
                    pp_wdata = {1'b0, idx_reg};
                end
                ph_next    = {1'b0, idx_reg};
                state_next = S_FIN;
            end

            S_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_st_reg;
                    m_data_next  = {5'd0, res_left_reg, res_slot_reg, res_addr_reg};
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memories: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[idx_reg] <= slot_wdata;
        end
        if (pn_we) begin
            pn_mem[pn_waddr] <= pn_wdata;
        end
        if (pp_we) begin
            pp_mem[pp_waddr] <= pp_wdata;
        end
        if (nf_we) begin
            nf_mem[nf_waddr] <= nf_wdata;
        end
        slot_rd_reg <= slot_mem[idx_reg];
        pn_rd_reg   <= pn_mem[idx_reg];
        pp_rd_reg   <= pp_mem[idx_reg];
        nf_rd_reg   <= nf_mem[nf_raddr];
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        k_reg         <= k_next;
        step_reg      <= step_next;
        addr_reg      <= addr_next;
        bad_reg       <= bad_next;
        rem_reg       <= rem_next;
        q_reg         <= q_next;
        slot_base_reg <= slot_base_next;
        prod_reg      <= prod_next;
        res_st_reg    <= res_st_next;
        res_addr_reg  <= res_addr_next;
        res_slot_reg  <= res_slot_next;
        res_left_reg  <= res_left_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

    // control and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ph_reg        <= NULL_S;
            in_use_reg    <= '0;
            m_valid_reg   <= 1'b0;
            base_reg      <= '0;
            shift_cfg_reg <= 5'd12;
            size_cfg_reg  <= 17'd64;
            objs_cfg_reg  <= 7'd64;
        end else begin
            state_reg   <= state_next;
            ph_reg      <= ph_next;
            in_use_reg  <= in_use_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_BASE_ADDRESS: base_reg      <= cfg_data;
                    CFG_SLAB_SHIFT:   shift_cfg_reg <= cfg_data[4:0];
                    CFG_OBJECT_SIZE:  size_cfg_reg  <= cfg_data[16:0];
                    CFG_OBJECTS:      objs_cfg_reg  <= cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

@@ sim/slab_object_allocator_checker.sv @@
// Scoreboard for the slab object allocator: tracks slot state and checks each result beat.
`timescale 1ns / 100ps
module slab_object_allocator_checker
    import soa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);
    localparam int NS = NUM_SLABS_DEF;
    localparam int MO = MAX_OBJECTS_DEF;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] addr;
        logic [3:0]  slab;
        logic [6:0]  left;
    } alloc_result_t;

    alloc_result_t expected_q[$];

    logic [31:0] base_r;
    logic [4:0]  shift_r;
    logic [16:0] size_r;
    logic [6:0]  objs_r;
    bit          in_use[NS];
    int          avail[NS];
    int          head_obj[NS];
    int          chain[NS*MO];
    int          plist_head;
    int          pnext[NS];
    int          pprev[NS];

    function automatic void unlink_slab(int s);
        int p, n;
        p = pprev[s];
        n = pnext[s];
        if (p < NS) pnext[p] = n; else plist_head = n;
        if (n < NS) pprev[n] = p;
    endfunction

    function automatic void push_slab(int s);
        pprev[s] = NS;
        pnext[s] = plist_head;
        if (plist_head < NS) pprev[plist_head] = s;
        plist_head = s;
    endfunction

    function automatic alloc_result_t serve_request(logic kind, logic [31:0] a);
        alloc_result_t r;
        int sh, sz, ob, s, k, o;
        logic [31:0] off, slab_off;
        sh = (shift_r < 12) ? 12 : (shift_r > 20) ? 20 : shift_r;
        sz = (size_r < 4) ? 4 : (size_r > 65536) ? 65536 : size_r;
        ob = (objs_r < 1) ? 1 : (objs_r > MO) ? MO : objs_r;
        r = '0;
        if (kind == REQ_ALLOC) begin
            if (plist_head < NS) begin
                s = plist_head;
            end else begin
                s = 0;
                while (s < NS && in_use[s]) s++;
                if (s >= NS) begin
                    r.status = ST_OUT_OF_SLABS;
                    return r;
                end
                in_use[s] = 1;
                avail[s] = ob;
                head_obj[s] = 0;
                for (k = 0; k < ob; k++) chain[s*MO+k] = (k + 1 < ob) ? k + 1 : 0;
                push_slab(s);
            end
            o = head_obj[s] % MO;
            head_obj[s] = chain[s*MO+o] % MO;
            if (avail[s] > 0) avail[s]--;
            if (avail[s] == 0) unlink_slab(s);
            r.status = ST_ALLOCATED;
            r.addr = base_r + (32'(s) << sh) + 32'(o) * 32'(sz);
            r.slab = s[3:0];
            r.left = avail[s][6:0];
            return r;
        end
        off = a - base_r;
        s = int'(off >> sh);
        slab_off = off & ((32'd1 << sh) - 1);
        if (off >> sh >= NS || !in_use[s] || slab_off % sz != 0 || slab_off / sz >= ob
                || avail[s] >= ob) begin
            r.status = ST_BAD_FREE;
            return r;
        end
        o = slab_off / sz;
        chain[s*MO+o] = head_obj[s];
        head_obj[s] = o;
        avail[s]++;
        r.slab = s[3:0];
        if (avail[s] == ob) begin
            if (avail[s] != 1) unlink_slab(s);
            in_use[s] = 0;
            avail[s] = 0;
            r.status = ST_RELEASED;
            r.left = ob[6:0];
            return r;
        end
        if (avail[s] == 1) push_slab(s);
        r.status = ST_FREED;
        r.left = avail[s][6:0];
        return r;
    endfunction

    assign pending_count = expected_q.size();

    always @(posedge aclk) begin
        alloc_result_t got, want;
        if (!aresetn) begin
            base_r <= 32'd0;
            shift_r <= 5'd12;
            size_r <= 17'd64;
            objs_r <= 7'd64;
            for (int i = 0; i < NS; i++) begin
                in_use[i] = 0;
                avail[i] = 0;
                head_obj[i] = 0;
                pnext[i] = 0;
                pprev[i] = 0;
            end
            for (int i = 0; i < NS*MO; i++) chain[i] = 0;
            plist_head = NS;
            fail_count <= 0;
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_BASE_ADDRESS: base_r <= cfg_data;
                    CFG_SLAB_SHIFT:   shift_r <= cfg_data[4:0];
                    CFG_OBJECT_SIZE:  size_r <= cfg_data[16:0];
                    CFG_OBJECTS:      objs_r <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[31:0], m_tdata[35:32], m_tdata[42:36]};
                if (expected_q.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result beat %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want || m_tdata[47:43] !== 5'd0) begin
                        if (fail_count < 10)
                            $display("result: exp st=%0d a=%h s=%0d l=%0d got st=%0d a=%h s=%0d l=%0d",
                                want.status, want.addr, want.slab, want.left,
                                got.status, got.addr, got.slab, got.left);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) expected_q.push_back(serve_request(s_tuser, s_tdata));
        end
    end
endmodule

@@ sim/tb_slab_object_allocator_top.sv @@
// Testbench top for the slab object allocator: stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps
module tb_slab_object_allocator_top;
    import soa_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending_count;
    int          send_idle_pct;   // chance per cycle that the sender holds off
    int          recv_stall_pct;  // chance per cycle that the receiver stalls
    int          quiet_cycles;    // cycles with no beat on any channel
    logic [31:0] live_objs[$];    // addresses handed out and not yet freed
    logic [31:0] cur_base;
    int          cur_shift, cur_size, cur_objs;

    localparam int WATCHDOG_LIMIT = 20000;

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    slab_object_allocator_top u_top (.*);

    slab_object_allocator_checker u_chk (.*);

    // receiver stall pattern
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: no beats for too long means the block has hung
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one request beat, with random hold-off before it
    task automatic send_beat(logic kind, logic [31:0] a);
        while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= a;
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // drain all results, then let any in-flight work settle
    task automatic wait_idle();
        while (pending_count != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // new setting, which changes the layout; objects_per_slab only changes once every slab
    // is released: the caller must ensure it, since this task itself does not enforce it
    task automatic configure(logic [31:0] b, int sh, int sz, int ob);
        wait_idle();
        write_reg(CFG_BASE_ADDRESS, b);
        write_reg(CFG_SLAB_SHIFT, sh);
        write_reg(CFG_OBJECT_SIZE, sz);
        write_reg(CFG_OBJECTS, ob);
        cur_base = b;
        cur_shift = (sh < 12) ? 12 : (sh > 20) ? 20 : sh;
        cur_size = (sz < 4) ? 4 : (sz > 65536) ? 65536 : sz;
        cur_objs = (ob < 1) ? 1 : (ob > 64) ? 64 : ob;
    endtask

    task automatic do_alloc();
        send_beat(REQ_ALLOC, $urandom);
        @(posedge aclk);
    endtask

    // release everything held so the next setting starts from empty slots
    task automatic free_all();
        wait_idle();
        while (live_objs.size() != 0) send_beat(REQ_FREE, live_objs.pop_front());
        wait_idle();
    endtask

    // track returned allocations so frees can hit real objects
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready && m_tuser == ST_ALLOCATED)
            live_objs.push_back(m_tdata[31:0]);
    end

    task automatic random_phase(int n);
        int idx;
        logic [31:0] a;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: send_beat(REQ_ALLOC, $urandom);
                4, 5, 6, 7: begin
                    if (live_objs.size() != 0) begin
                        idx = $urandom_range(live_objs.size() - 1);
                        a = live_objs[idx];
                        live_objs.delete(idx);
                        send_beat(REQ_FREE, a);
                    end else begin
                        send_beat(REQ_ALLOC, 32'd0);
                    end
                end
                8: send_beat(REQ_FREE, $urandom);
                default: begin
                    // near-miss: misaligned or past the pool
                    a = cur_base + ($urandom_range(17) << cur_shift)
                        + $urandom_range(cur_size * 2);
                    send_beat(REQ_FREE, a);
                end
            endcase
        end
    endtask

    task automatic set_pace(int sp, int rp);
        send_idle_pct = sp;
        recv_stall_pct = rp;
    endtask

    initial begin
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = REQ_ALLOC;
        cfg_valid = 0;
        cfg_index = CFG_BASE_ADDRESS;
        cfg_data = '0;
        set_pace(0, 0);
        cur_base = 0; cur_shift = 12; cur_size = 64; cur_objs = 64;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: defaults, bad frees before anything is in use, edge addresses
        send_beat(REQ_FREE, 32'd0);
        send_beat(REQ_FREE, 32'hFFFF_FFFF);
        send_beat(REQ_ALLOC, 32'hFFFF_FFFF);
        send_beat(REQ_ALLOC, 32'd0);
        wait_idle();
        send_beat(REQ_FREE, 32'd64);
        send_beat(REQ_FREE, 32'd64);       // double free accepted: count reaches full, released
        send_beat(REQ_FREE, 32'd3);        // not on object boundary
        send_beat(REQ_FREE, 32'h0001_0000); // past the last slot
        send_beat(REQ_FREE, 32'd0);        // slot no longer in use
        live_objs.delete();
        // clamped extremes: one object per slab, exhaust the pool
        configure(32'hFFFF_F000, 0, 0, 0);
        repeat (17) send_beat(REQ_ALLOC, 32'd0);   // 16 slabs then out of slabs
        free_all();
        configure(32'hFFFF_FFFF, 31, 17'h1FFFF, 127);
        send_beat(REQ_ALLOC, 32'd0);
        send_beat(REQ_ALLOC, 32'd0);
        free_all();

        // random phases across settings and pacing
        set_pace(0, 0);
        random_phase(400);
        free_all();
        configure($urandom, $urandom_range(12, 14), 4 << $urandom_range(0, 4),
                  $urandom_range(1, 4));
        set_pace(66, 0);
        random_phase(350);
        // hold off until every expected result has come
        wait_idle();
        set_pace(0, 66);
        random_phase(350);
        free_all();
        configure(32'h8000_0000, 20, 65536, 16);
        set_pace(29, 29);
        random_phase(350);
        free_all();
        configure($urandom, 12, 64, 64);
        set_pace(0, 0);
        random_phase(450);

        wait_idle();
        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

@@ slab_object_allocator_top.f @@
design/soa_pkg.sv
design/slab_object_allocator_top.sv
sim/slab_object_allocator_checker.sv
sim/tb_slab_object_allocator_top.sv
